>>> src/mixed_radix_counter_unit_assert.svh
// Assertion macros for the mixed-radix counter blocks.
`ifndef MIXED_RADIX_COUNTER_UNIT_ASSERT_SVH
`define MIXED_RADIX_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clock, masked during reset.
`define MRC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, masked during reset.
`define MRC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/mrc_pkg.sv
// Shared constants, types and command codes for the mixed-radix counter.
`default_nettype none
package mrc_pkg;
   localparam int MAX_DIGITS  = 4;
   localparam int DIGIT_W     = 15;
   localparam int VAL_W       = 60;
   localparam int DIV_W       = VAL_W + 2;
   localparam int DIV_CW      = $clog2(DIV_W + 1);
   localparam int IDX_W       = $clog2(MAX_DIGITS);
   localparam int NDIG_W      = 3;
   localparam int BIT_CW      = $clog2(DIGIT_W + 1);
   localparam int REQ_TDATA_W = 64;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 128;
   localparam int CSR_IDX_W   = 3;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [VAL_W-1:0]   value_type;
   typedef logic [IDX_W-1:0]   dsel_type;

   typedef enum logic [2:0] {
      CMD_INC  = 3'd0,
      CMD_DEC  = 3'd1,
      CMD_LOAD = 3'd2,
      CMD_ADD  = 3'd3,
      CMD_SUB  = 3'd4,
      CMD_SET  = 3'd5,
      CMD_CMP  = 3'd6
   } cmd_type;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIGITS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX_0    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX_3    = 3'd4;

   // status from the Horner unit to the sequencer
   typedef struct packed {
      logic     done;
      dsel_type idx;
   } horner_stat_type;
endpackage
`default_nettype wire

>>> src/mrc_horner.sv
// Bit-serial Horner unit: radix product and linear index over the active digits.
`default_nettype none
module mrc_horner (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2:0]               n_active,
   input  mrc_pkg::digit_type       digit_in,
   input  mrc_pkg::digit_type       radix_in,
   output mrc_pkg::horner_stat_type stat,
   output mrc_pkg::value_type       prod,
   output mrc_pkg::value_type       index
);
   import mrc_pkg::*;

   logic              busy_ff, busy_in, done_ff, done_in;
   dsel_type          k_ff, k_in;
   logic [BIT_CW-1:0] cnt_ff, cnt_in, bsel;
   value_type         v_ff, v_in, p_ff, p_in, av_ff, av_in, ap_ff, ap_in;
   value_type         av_sh, ap_sh;
   logic              rbit, last_digit;

   always_comb begin
      bsel       = BIT_CW'(DIGIT_W - 1) - cnt_ff;
      rbit       = (cnt_ff == BIT_CW'(DIGIT_W)) ? 1'b0 : radix_in[bsel[IDX_W+1:0]];
      av_sh      = (cnt_ff == '0) ? '0 : {av_ff[VAL_W-2:0], 1'b0};
      ap_sh      = (cnt_ff == '0) ? '0 : {ap_ff[VAL_W-2:0], 1'b0};
      last_digit = ({1'b0, k_ff} == (n_active - 3'd1));
      busy_in = busy_ff;
      done_in = 1'b0;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      v_in    = v_ff;
      p_in    = p_ff;
      av_in   = av_ff;
      ap_in   = ap_ff;
      if (start) begin
         busy_in = 1'b1;
         k_in    = '0;
         cnt_in  = '0;
         v_in    = '0;
         p_in    = VAL_W'(1);
      end else if (busy_ff) begin
         if (cnt_ff == BIT_CW'(DIGIT_W)) begin
            v_in   = av_ff + VAL_W'(digit_in);
            p_in   = ap_ff;
            cnt_in = '0;
            if (last_digit) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end else begin
            av_in  = av_sh + (rbit ? v_ff : '0);
            ap_in  = ap_sh + (rbit ? p_ff : '0);
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         k_ff    <= '0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         k_ff    <= k_in;
         cnt_ff  <= cnt_in;
      end
      v_ff  <= v_in;
      p_ff  <= p_in;
      av_ff <= av_in;
      ap_ff <= ap_in;
   end

   assign stat.done = done_ff;
   assign stat.idx  = k_ff;
   assign prod      = p_ff;
   assign index     = v_ff;
endmodule
`default_nettype wire

>>> src/mrc_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module mrc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mrc_pkg::DIV_W-1:0]      dividend,
   input  mrc_pkg::value_type             divisor,
   output logic                           done,
   output logic [mrc_pkg::DIV_W-1:0]      quotient,
   output mrc_pkg::value_type             remainder
);
   import mrc_pkg::*;

   logic [DIV_W-1:0]  x_ff, x_in;
   value_type         r_ff, r_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [VAL_W:0]    t, diff;
   logic              ge;

   always_comb begin
      t       = {r_ff, x_ff[DIV_W-1]};
      ge      = (t >= {1'b0, divisor});
      diff    = t - {1'b0, divisor};
      x_in    = x_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = dividend;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = ge ? diff[VAL_W-1:0] : t[VAL_W-1:0];
         x_in   = {x_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      r_ff <= r_in;
   end

   assign done      = done_ff;
   assign quotient  = x_ff;
   assign remainder = r_ff;
endmodule
`default_nettype wire

>>> src/mixed_radix_counter_unit.sv
// Mixed-radix up/down counter: sequencer, digit store, config and result register.
//
//  channel | dir | handshake                 | payload
//  req     | in  | req_tvalid / req_tready   | tdata: operand, digit_select; tuser: cmd
//  rsp     | out | rsp_tvalid / rsp_tready   | tdata: index, digits, flags
//  csr     | in  | csr_valid  / csr_ready    | csr_index, csr_data
//
// One request at a time. A request runs a Horner pass over the n active digits,
// then inc/dec ripple over at most n digits, or one divide by the radix product
// plus n divides by the radices on the shared restoring divider (subtract adds a
// second divide by the product to reduce the difference), and for inc/dec/set
// digit a second Horner pass.
// Synchronous reset: digits 0, wrap flag 0, one digit, all radices 1.
// A finished response waits in the output register; the next request is taken
// meanwhile and only stalls at its end if the previous response is still held.
`default_nettype none
`include "mixed_radix_counter_unit_assert.svh"
module mixed_radix_counter_unit (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: operand[59:0], digit_select[61:60], zero [63:62]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mrc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // tuser: cmd[2:0]
   input  logic [mrc_pkg::REQ_TUSER_W-1:0]     req_tuser,
   // tdata: linear_index[59:0], digit_0..digit_3[119:60], wrapped[120],
   //        is_less[121], is_equal[122], is_greater[123], zero [127:124]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [mrc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mrc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mrc_pkg::DIGIT_W-1:0]         csr_data
);
   import mrc_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_HORN = 10'b0000000010,
      ST_EXEC = 10'b0000000100,
      ST_RIPL = 10'b0000001000,
      ST_DIVP = 10'b0000010000,
      ST_FIXP = 10'b0000100000,
      ST_DECO = 10'b0001000000,
      ST_POST = 10'b0010000000,
      ST_FIN  = 10'b0100000000,
      ST_MODP = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // config registers
   logic [NDIG_W-1:0] ndig_ff;
   digit_type         radix_ff [MAX_DIGITS];

   // counter state
   digit_type digits_ff [MAX_DIGITS];
   digit_type digits_in [MAX_DIGITS];
   logic      wrap_ff, wrap_in;

   // request and working registers
   logic [2:0]       cmd_ff;
   value_type        opnd_ff;
   dsel_type         sel_ff;
   logic             lt_ff, lt_in, eq_ff, eq_in, gt_ff, gt_in;
   value_type        prod_ff, prod_in, cur_ff, cur_in, lin_ff, lin_in, val_ff, val_in;
   logic             borrow_ff, borrow_in, kick_ff, kick_in;
   dsel_type         rip_ff, rip_in, dec_ff, dec_in;
   logic [DIV_W-1:0] div_a_ff, div_a_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // datapath
   logic [2:0]       n_act;
   dsel_type         cur_idx;
   digit_type        digit_rd, radix_raw, radix_rd, wd;
   logic             we, accept, rsp_load, hstart, fin;
   logic [DIGIT_W:0] inc_sum;
   logic [VAL_W:0]   sub_diff;
   value_type        fix_val, div_b;
   horner_stat_type  hstat;
   value_type        hprod, hidx;
   logic             div_done;
   logic [DIV_W-1:0] dquot;
   value_type        drem;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      if (ndig_ff == '0) begin
         n_act = 3'd1;
      end else if (ndig_ff > NDIG_W'(MAX_DIGITS)) begin
         n_act = NDIG_W'(MAX_DIGITS);
      end else begin
         n_act = ndig_ff;
      end
   end

   // one shared digit/radix read address, chosen by the phase
   always_comb begin
      if (state_ff == ST_HORN || state_ff == ST_POST) begin
         cur_idx = hstat.idx;
      end else if (state_ff == ST_RIPL) begin
         cur_idx = rip_ff;
      end else if (state_ff == ST_EXEC) begin
         cur_idx = sel_ff;
      end else begin
         cur_idx = dec_ff;
      end
   end

   assign digit_rd  = digits_ff[cur_idx];
   assign radix_raw = radix_ff[cur_idx];
   assign radix_rd  = (radix_raw == '0) ? DIGIT_W'(1) : radix_raw;
   assign div_b     = (state_ff == ST_DIVP || state_ff == ST_MODP) ? prod_ff
                                                                   : VAL_W'(radix_rd);
   assign inc_sum   = {1'b0, digit_rd} + 1'b1;
   assign sub_diff  = {1'b0, cur_ff} - {1'b0, drem};
   assign fix_val   = borrow_ff ? (val_ff + prod_ff) : val_ff;
   assign rsp_load  = (state_ff == ST_FIN) & (~rsp_valid_ff | rsp_tready);

   mrc_horner u_horner (
      .clock    (clock),
      .reset    (reset),
      .start    (hstart),
      .n_active (n_act),
      .digit_in (digit_rd),
      .radix_in (radix_rd),
      .stat     (hstat),
      .prod     (hprod),
      .index    (hidx)
   );

   mrc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (kick_ff),
      .dividend  (div_a_ff),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (dquot),
      .remainder (drem)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      wrap_in   = wrap_ff;
      lt_in     = lt_ff;
      eq_in     = eq_ff;
      gt_in     = gt_ff;
      prod_in   = prod_ff;
      cur_in    = cur_ff;
      lin_in    = lin_ff;
      val_in    = val_ff;
      borrow_in = borrow_ff;
      kick_in   = 1'b0;
      rip_in    = rip_ff;
      dec_in    = dec_ff;
      div_a_in  = div_a_ff;
      hstart    = 1'b0;
      we        = 1'b0;
      wd        = digit_rd;
      fin       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lt_in    = 1'b0;
               eq_in    = 1'b0;
               gt_in    = 1'b0;
               hstart   = 1'b1;
               state_in = ST_HORN;
            end
         end
         ST_HORN: begin
            if (hstat.done) begin
               prod_in  = hprod;
               cur_in   = hidx;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_INC, CMD_DEC: begin
                  rip_in   = dsel_type'(n_act - 3'd1);
                  state_in = ST_RIPL;
               end
               CMD_LOAD, CMD_SUB: begin
                  div_a_in = DIV_W'(opnd_ff);
                  kick_in  = 1'b1;
                  state_in = ST_DIVP;
               end
               CMD_ADD: begin
                  div_a_in = DIV_W'(cur_ff) + DIV_W'(opnd_ff);
                  kick_in  = 1'b1;
                  state_in = ST_DIVP;
               end
               CMD_SET: begin
                  if (({1'b0, sel_ff} < n_act) && (opnd_ff < VAL_W'(radix_rd))) begin
                     we = 1'b1;
                     wd = opnd_ff[DIGIT_W-1:0];
                  end
                  hstart   = 1'b1;
                  state_in = ST_POST;
               end
               CMD_CMP: begin
                  lt_in    = (cur_ff < opnd_ff);
                  eq_in    = (cur_ff == opnd_ff);
                  gt_in    = (cur_ff > opnd_ff);
                  lin_in   = cur_ff;
                  state_in = ST_FIN;
               end
               default: begin
                  lin_in   = cur_ff;
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_RIPL: begin
            // carry/borrow ripples from the fastest digit towards digit 0
            we = 1'b1;
            if (cmd_ff == CMD_INC) begin
               if (inc_sum < {1'b0, radix_rd}) begin
                  wd  = inc_sum[DIGIT_W-1:0];
                  fin = 1'b1;
               end else begin
                  wd = '0;
               end
            end else begin
               if (digit_rd != '0) begin
                  wd  = digit_rd - 1'b1;
                  fin = 1'b1;
               end else begin
                  wd = radix_rd - 1'b1;
               end
            end
            if (!fin) begin
               if (rip_ff == '0) begin
                  wrap_in = 1'b1;
                  fin     = 1'b1;
               end else begin
                  rip_in = rip_ff - 1'b1;
               end
            end
            if (fin) begin
               hstart   = 1'b1;
               state_in = ST_POST;
            end
         end
         ST_DIVP: begin
            if (div_done) begin
               if (cmd_ff == CMD_SUB) begin
                  borrow_in = sub_diff[VAL_W];
                  val_in    = sub_diff[VAL_W-1:0];
                  wrap_in   = sub_diff[VAL_W];
               end else begin
                  borrow_in = 1'b0;
                  val_in    = drem;
                  wrap_in   = (dquot != '0);
               end
               state_in = ST_FIXP;
            end
         end
         ST_FIXP: begin
            div_a_in = DIV_W'(fix_val);
            kick_in  = 1'b1;
            if (cmd_ff == CMD_SUB) begin
               // difference may still reach the product when a digit sits above its radix
               state_in = ST_MODP;
            end else begin
               lin_in   = fix_val;
               dec_in   = dsel_type'(n_act - 3'd1);
               state_in = ST_DECO;
            end
         end
         ST_MODP: begin
            if (div_done) begin
               wrap_in  = wrap_ff | (dquot != '0);
               lin_in   = drem;
               div_a_in = DIV_W'(drem);
               dec_in   = dsel_type'(n_act - 3'd1);
               kick_in  = 1'b1;
               state_in = ST_DECO;
            end
         end
         ST_DECO: begin
            if (div_done) begin
               we = 1'b1;
               wd = drem[DIGIT_W-1:0];
               if (dec_ff == '0) begin
                  state_in = ST_FIN;
               end else begin
                  dec_in   = dec_ff - 1'b1;
                  div_a_in = dquot;
                  kick_in  = 1'b1;
               end
            end
         end
         ST_POST: begin
            if (hstat.done) begin
               lin_in   = hidx;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digits_in[i] = digits_ff[i];
      end
      if (we) begin
         digits_in[cur_idx] = wd;
      end
   end

   always_comb begin
      rsp_valid_in = (rsp_valid_ff & ~rsp_tready) | rsp_load;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in = {4'b0000, gt_ff, eq_ff, lt_ff, wrap_ff,
                        digits_ff[3], digits_ff[2], digits_ff[1], digits_ff[0], lin_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ndig_ff      <= NDIG_W'(1);
         wrap_ff      <= 1'b0;
         kick_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            radix_ff[i]  <= DIGIT_W'(1);
            digits_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wrap_ff      <= wrap_in;
         kick_ff      <= kick_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digits_ff[i] <= digits_in[i];
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUM_DIGITS) begin
               ndig_ff <= csr_data[NDIG_W-1:0];
            end else if (csr_index >= CSR_RADIX_0 && csr_index <= CSR_RADIX_3) begin
               radix_ff[dsel_type'(csr_index - CSR_RADIX_0)] <= csr_data;
            end
         end
      end
      if (accept) begin
         cmd_ff  <= req_tuser[2:0];
         opnd_ff <= req_tdata[VAL_W-1:0];
         sel_ff  <= req_tdata[VAL_W+IDX_W-1:VAL_W];
      end
      lt_ff       <= lt_in;
      eq_ff       <= eq_in;
      gt_ff       <= gt_in;
      prod_ff     <= prod_in;
      cur_ff      <= cur_in;
      lin_ff      <= lin_in;
      val_ff      <= val_in;
      borrow_ff   <= borrow_in;
      rip_ff      <= rip_in;
      dec_ff      <= dec_in;
      div_a_ff    <= div_a_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MRC_ASSERT_IMP(a_div_done_phase, div_done, (state_ff == ST_DIVP) || (state_ff == ST_MODP) || (state_ff == ST_DECO), "divider finished outside a divide phase")
   `MRC_ASSERT_IMP(a_horner_done_phase, hstat.done, (state_ff == ST_HORN) || (state_ff == ST_POST), "Horner unit finished outside a Horner phase")
   `MRC_ASSERT_NXT(a_accept_starts_horner, accept, state_ff == ST_HORN, "accepted request did not start the Horner pass")
   `MRC_ASSERT_NXT(a_fin_loads_rsp, (state_ff == ST_FIN) && !rsp_valid_ff, rsp_valid_ff && (state_ff == ST_IDLE), "free response register not loaded")
endmodule
`default_nettype wire
